### rtl/base64_stream_decoder_top_macros.svh
// Assertion helpers for the checker file b64d_checker.sv.
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define B64D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/b64d_pkg.sv
package b64d_pkg;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PAD    = 8'h3D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    localparam logic [5:0] SX_LOWER_BASE = 6'd26;
    localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SX_PLUS       = 6'd62;
    localparam logic [5:0] SX_SLASH      = 6'd63;

    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } sextet_t;

    // One decoded quartet and/or end-of-string status, as queued for output.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] nbytes;
        logic       has_status;
        logic       success;
    } job_t;

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t    s;
        logic [7:0] d;
        s.bad = 1'b0;
        s.val = '0;
        d     = '0;
        priority if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            d     = ch - CH_UPPER_A;
            s.val = d[5:0];
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            d     = ch - CH_LOWER_A;
            s.val = d[5:0] + SX_LOWER_BASE;
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            d     = ch - CH_DIGIT_0;
            s.val = d[5:0] + SX_DIGIT_BASE;
        end else if (ch == CH_PLUS) begin
            s.val = SX_PLUS;
        end else if (ch == CH_SLASH) begin
            s.val = SX_SLASH;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

### rtl/b64d_front.sv
module b64d_front
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_code
    input  logic       s_tlast,   // end_of_text
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic [5:0] sx_reg   [3];
    logic [5:0] sx_next  [3];
    logic [1:0] pos_reg, pos_next;
    logic [1:0] pad_cnt_reg, pad_cnt_next;
    logic [1:0] mask_reg, mask_next;
    logic       err_reg, err_next;
    logic       any_reg, any_next;

    logic       accept;
    logic       space;
    logic       is_pad;
    sextet_t    sx;
    logic [5:0] v;
    logic       err_final;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign space    = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB) ||
                      (s_tdata == CH_CR) || (s_tdata == CH_LF);
    assign is_pad   = (s_tdata == CH_PAD);
    assign sx       = sextet_of(s_tdata);
    assign v        = (is_pad || sx.bad) ? 6'd0 : sx.val;

    always_comb begin
        sx_next      = sx_reg;
        pos_next     = pos_reg;
        pad_cnt_next = pad_cnt_reg;
        mask_next    = mask_reg;
        err_next     = err_reg;
        any_next     = any_reg;
        err_final    = 1'b0;
        q_job        = '0;

        if (accept) begin
            if (!space) begin
                any_next = 1'b1;
                if (is_pad) begin
                    if (pad_cnt_reg == 2'd2) begin
                        err_next = 1'b1;
                    end else begin
                        pad_cnt_next = pad_cnt_reg + 2'd1;
                    end
                    if (pos_reg == 2'd2) begin
                        mask_next[0] = 1'b1;
                    end
                    if (pos_reg == 2'd3) begin
                        mask_next[1] = 1'b1;
                    end
                end else if (sx.bad || pad_cnt_reg != 2'd0) begin
                    err_next = 1'b1;
                end

                unique case (pos_reg)
                    2'd0: begin
                        sx_next[0] = v;
                        pos_next   = 2'd1;
                    end
                    2'd1: begin
                        sx_next[1] = v;
                        pos_next   = 2'd2;
                    end
                    2'd2: begin
                        sx_next[2] = v;
                        pos_next   = 2'd3;
                    end
                    default: begin
                        q_job.byte0 = {sx_reg[0], sx_reg[1][5:4]};
                        q_job.byte1 = {sx_reg[1][3:0], sx_reg[2][5:2]};
                        q_job.byte2 = {sx_reg[2][1:0], v};
                        if (!err_next) begin
                            priority if (mask_next[0]) begin
                                q_job.nbytes = 2'd1;
                            end else if (mask_next[1]) begin
                                q_job.nbytes = 2'd2;
                            end else begin
                                q_job.nbytes = 2'd3;
                            end
                        end
                        pos_next  = 2'd0;
                        mask_next = 2'd0;
                    end
                endcase
            end

            if (s_tlast) begin
                err_final        = err_next || !any_next || (pos_next != 2'd0);
                q_job.has_status = 1'b1;
                q_job.success    = !err_final;
                pos_next         = 2'd0;
                pad_cnt_next     = 2'd0;
                mask_next        = 2'd0;
                err_next         = 1'b0;
                any_next         = 1'b0;
            end
        end
    end

    assign q_push = accept && ((q_job.nbytes != 2'd0) || q_job.has_status);

    // sextets are always written before read within a quartet
    always_ff @(posedge aclk) begin
        sx_reg <= sx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 2'd0;
            pad_cnt_reg <= 2'd0;
            mask_reg    <= 2'd0;
            err_reg     <= 1'b0;
            any_reg     <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            pad_cnt_reg <= pad_cnt_next;
            mask_reg    <= mask_next;
            err_reg     <= err_next;
            any_reg     <= any_next;
        end
    end

endmodule

### rtl/b64d_fifo.sv
module b64d_fifo
    import b64d_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/b64d_back.sv
module b64d_back
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // data_byte
    output logic [1:0] m_tuser,   // is_status, success
    output logic       m_tlast    // final_result
);

    logic [1:0] sel_reg, sel_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic [1:0] m_tuser_reg, m_tuser_next;
    logic       m_tlast_reg, m_tlast_next;

    logic [2:0] total;
    logic       sel_last;
    logic       load;

    // words per job: data bytes first, then the status word if any
    assign total    = {1'b0, q_job.nbytes} + {2'b00, q_job.has_status};
    assign sel_last = ({1'b0, sel_reg} + 3'd1) == total;
    assign load     = q_valid && (!m_tvalid_reg || m_tready);
    assign q_pop    = load && sel_last;

    always_comb begin
        if (sel_reg < q_job.nbytes) begin
            unique case (sel_reg)
                2'd0:    m_tdata_next = q_job.byte0;
                2'd1:    m_tdata_next = q_job.byte1;
                default: m_tdata_next = q_job.byte2;
            endcase
            m_tuser_next = 2'b00;
            m_tlast_next = 1'b0;
        end else begin
            m_tdata_next = 8'd0;
            m_tuser_next = {q_job.success, 1'b1};
            m_tlast_next = 1'b1;
        end
    end

    always_comb begin
        sel_next      = sel_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            sel_next      = sel_last ? 2'd0 : sel_reg + 2'd1;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            sel_reg      <= sel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/base64_stream_decoder_top.sv
// A result word passes through the job queue and then the output register before m_tvalid rises.
// Throughput: one character accepted per cycle while the job queue has room; the output
// side sends one word per cycle while m_tready is high, a job's data bytes and then its status.
// Queue depth (QUEUE_DEPTH jobs) sets how long the input can run ahead of a stalled output.
// Reset: synchronous, active-low aresetn clears decoder state, queue and output valid.
module base64_stream_decoder_top
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [0] is_status, [1] success
    output logic       m_tlast    // final_result
);

    logic q_full;
    logic q_push;
    job_t q_job_in;
    logic q_valid;
    job_t q_job_out;
    logic q_pop;

    b64d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job_in)
    );

    b64d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job_in),
        .full       (q_full),
        .head_valid (q_valid),
        .head_job   (q_job_out),
        .pop        (q_pop)
    );

    b64d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/b64d_checker.sv
`include "base64_stream_decoder_top_macros.svh"

module b64d_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    `B64D_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output word changed while stalled")

    `B64D_ASSERT_NOW(a_last_is_status, m_tvalid && m_tlast, m_tuser[0] && (m_tdata == 8'd0), "tlast word is not a zero-data status word")

    `B64D_ASSERT_NOW(a_status_is_last, m_tvalid && m_tuser[0], m_tlast, "status word without tlast")

    `B64D_ASSERT_NOW(a_byte_no_success, m_tvalid && !m_tuser[0], !m_tuser[1], "data word carries success flag")

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (.*);
